### hw/rtl/mva_pkg.sv
// ----------------------------------------------------------------------------
// mva_pkg
// Shared types and constants for the mesh volume accumulator.
// ----------------------------------------------------------------------------
package mva_pkg;

  localparam int unsigned VertexDepthDflt = 4096;
  localparam int unsigned DivSteps        = 7;

  typedef enum logic [1:0] {
    MODE_STORE  = 2'd0,
    MODE_FACE   = 2'd1,
    MODE_FINISH = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    SEL_SLOT,
    SEL_A,
    SEL_B,
    SEL_C
  } rd_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_A,
    ST_RD_B,
    ST_RD_C,
    ST_CAP_C,
    ST_MUL1,
    ST_MUL2,
    ST_SUM,
    ST_ACC,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic    store;
    logic    load_item;
    rd_sel_e rd_sel;
    logic    cap_a;
    logic    cap_b;
    logic    cap_c;
    logic    mul1;
    logic    mul2;
    logic    sum;
    logic    acc;
    logic    div_load;
    logic    div_step;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic out_busy;
  } status_t;

endpackage

### hw/rtl/mva_ctrl.sv
// ----------------------------------------------------------------------------
// mva_ctrl
// Sequencer: vertex fetch, determinant steps, accumulate and divide-by-six.
// ----------------------------------------------------------------------------
module mva_ctrl
  import mva_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic [1:0]  mode_i,
  input  status_t     status_i,
  output logic        in_ready_o,
  output cmd_t        cmd_o
);

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && mode_i == MODE_FACE) state_d = ST_RD_A;
        else if (accept && mode_i == MODE_FINISH) state_d = ST_DIV;
      end
      ST_RD_A:  state_d = ST_RD_B;
      ST_RD_B:  state_d = ST_RD_C;
      ST_RD_C:  state_d = ST_CAP_C;
      ST_CAP_C: state_d = ST_MUL1;
      ST_MUL1:  state_d = ST_MUL2;
      ST_MUL2:  state_d = ST_SUM;
      ST_SUM:   state_d = ST_ACC;
      ST_ACC:   state_d = ST_IDLE;
      ST_DIV: begin
        if (status_i.div_last) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!status_i.out_busy) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o = '0;
    cmd_o.rd_sel = SEL_SLOT;
    case (state_q)
      ST_IDLE: begin
        cmd_o.load_item = accept;
        cmd_o.store     = accept && (mode_i == MODE_STORE);
        cmd_o.div_load  = accept && (mode_i == MODE_FINISH);
      end
      ST_RD_A: cmd_o.rd_sel = SEL_A;
      ST_RD_B: begin
        cmd_o.rd_sel = SEL_B;
        cmd_o.cap_a  = 1'b1;
      end
      ST_RD_C: begin
        cmd_o.rd_sel = SEL_C;
        cmd_o.cap_b  = 1'b1;
      end
      ST_CAP_C: cmd_o.cap_c = 1'b1;
      ST_MUL1:  cmd_o.mul1 = 1'b1;
      ST_MUL2:  cmd_o.mul2 = 1'b1;
      ST_SUM:   cmd_o.sum = 1'b1;
      ST_ACC:   cmd_o.acc = 1'b1;
      ST_DIV:   cmd_o.div_step = 1'b1;
      ST_OUT:   cmd_o.out_load = !status_i.out_busy;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### hw/rtl/mva_datapath.sv
// ----------------------------------------------------------------------------
// mva_datapath
// Vertex memory, determinant and sign arithmetic, saturating accumulator,
// multi-step divide by six and the result register.
// ----------------------------------------------------------------------------
module mva_datapath
  import mva_pkg::*;
#(
  parameter int unsigned VERTEX_DEPTH = VertexDepthDflt
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output status_t            status_o,
  input  logic [11:0]        vertex_slot_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic signed [15:0] pos_z_i,
  input  logic signed [15:0] norm_x_i,
  input  logic signed [15:0] norm_y_i,
  input  logic signed [15:0] norm_z_i,
  input  logic [11:0]        face_a_i,
  input  logic [11:0]        face_b_i,
  input  logic [11:0]        face_c_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [63:0] volume_o,
  output logic [31:0]        faces_seen_o,
  output logic               saturated_o
);

  localparam int unsigned AW = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
  localparam int unsigned CW = $clog2(DivSteps);

  // face corner indices held for the fetch sequence
  logic [11:0] fa_q, fb_q, fc_q;
  logic [11:0] idx;
  logic        idx_ok;
  logic [AW-1:0] addr;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      fa_q <= face_a_i;
      fb_q <= face_b_i;
      fc_q <= face_c_i;
    end
  end

  always_comb begin
    case (cmd_i.rd_sel)
      SEL_SLOT: idx = vertex_slot_i;
      SEL_A:    idx = fa_q;
      SEL_B:    idx = fb_q;
      SEL_C:    idx = fc_q;
      default:  idx = vertex_slot_i;
    endcase
  end

  assign idx_ok = (17'(idx) < 17'(VERTEX_DEPTH));
  assign addr   = AW'(idx);

  // single-port vertex memory: {norm z,y,x, pos z,y,x}
  logic [95:0] mem [VERTEX_DEPTH];
  logic [95:0] rd_q;
  logic        rd_ok_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.store && idx_ok) begin
      mem[addr] <= {norm_z_i, norm_y_i, norm_x_i, pos_z_i, pos_y_i, pos_x_i};
    end
    rd_q    <= mem[addr];
    rd_ok_q <= idx_ok;
  end

  // corner capture, out-of-range corners read as zero
  logic signed [15:0] pa_q [3], pb_q [3], pc_q [3];
  logic signed [15:0] na_q [3], nb_q [3], nc_q [3];
  logic [95:0] rd_v;

  assign rd_v = rd_ok_q ? rd_q : '0;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      if (cmd_i.cap_a) begin
        pa_q[k] <= rd_v[16*k +: 16];
        na_q[k] <= rd_v[48+16*k +: 16];
      end
      if (cmd_i.cap_b) begin
        pb_q[k] <= rd_v[16*k +: 16];
        nb_q[k] <= rd_v[48+16*k +: 16];
      end
      if (cmd_i.cap_c) begin
        pc_q[k] <= rd_v[16*k +: 16];
        nc_q[k] <= rd_v[48+16*k +: 16];
      end
    end
  end

  // step 1: cross-product terms of b and c, corner sums
  logic signed [31:0] x_q [6];
  logic signed [17:0] sa_q [3], sn_q [3];

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul1) begin
      x_q[0] <= 32'(pb_q[1]) * 32'(pc_q[2]);
      x_q[1] <= 32'(pb_q[2]) * 32'(pc_q[1]);
      x_q[2] <= 32'(pb_q[2]) * 32'(pc_q[0]);
      x_q[3] <= 32'(pb_q[0]) * 32'(pc_q[2]);
      x_q[4] <= 32'(pb_q[0]) * 32'(pc_q[1]);
      x_q[5] <= 32'(pb_q[1]) * 32'(pc_q[0]);
      for (int k = 0; k < 3; k++) begin
        sa_q[k] <= 18'(pa_q[k]) + 18'(pb_q[k]) + 18'(pc_q[k]);
        sn_q[k] <= 18'(na_q[k]) + 18'(nb_q[k]) + 18'(nc_q[k]);
      end
    end
  end

  // step 2: a times cross product, sign products
  logic signed [32:0] m [3];
  logic signed [48:0] t_q [3];
  logic signed [35:0] d_q [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      m[k] = 33'(x_q[2*k]) - 33'(x_q[2*k+1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul2) begin
      for (int k = 0; k < 3; k++) begin
        t_q[k] <= 49'(pa_q[k]) * 49'(m[k]);
        d_q[k] <= 36'(sa_q[k]) * 36'(sn_q[k]);
      end
    end
  end

  // step 3: determinant magnitude and direction
  logic signed [50:0] det;
  logic signed [37:0] sgn;
  logic signed [50:0] mag_q;
  logic               sub_q;

  assign det = 51'(t_q[0]) + 51'(t_q[1]) + 51'(t_q[2]);
  assign sgn = 38'(d_q[0]) + 38'(d_q[1]) + 38'(d_q[2]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum) begin
      mag_q <= det[50] ? -det : det;
      sub_q <= (sgn > 0);
    end
  end

  // saturating accumulator and face count
  logic signed [63:0] sum_q;
  logic [31:0]        cnt_q;
  logic               clip_q;
  logic signed [64:0] sum_x;

  assign sum_x = 65'(sum_q) + (sub_q ? -65'(mag_q) : 65'(mag_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      cnt_q  <= '0;
      clip_q <= 1'b0;
    end else if (cmd_i.div_load) begin
      sum_q  <= '0;
      cnt_q  <= '0;
      clip_q <= 1'b0;
    end else if (cmd_i.acc) begin
      cnt_q <= cnt_q + 32'd1;
      if (sum_x[64] != sum_x[63]) begin
        sum_q  <= sum_x[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        clip_q <= 1'b1;
      end else begin
        sum_q <= sum_x[63:0];
      end
    end
  end

  // divide |sum| by six: halve, multiply by the inverse of three modulo 2^64
  // (one shift and add a step), then keep the one of the three residue
  // candidates whose top bits are clear
  localparam logic [63:0] Inv3   = 64'hAAAA_AAAA_AAAA_AAAB;
  localparam logic [63:0] Inv3x2 = 64'h5555_5555_5555_5556;

  logic [63:0]   half_q;
  logic [63:0]   quo_q;
  logic [CW-1:0] step_q;
  logic          neg_q;
  logic [31:0]   cnt_hold_q;
  logic          clip_hold_q;
  logic [63:0]   mag_s;
  logic [63:0]   add_a, add_b;
  logic [63:0]   quo_m1, quo_m2, quo_sel;

  assign mag_s = sum_q[63] ? 64'(-sum_q) : sum_q;

  always_comb begin
    case (step_q)
      CW'(0): begin
        add_a = half_q;
        add_b = half_q << 2;
      end
      CW'(1): begin
        add_a = quo_q;
        add_b = quo_q << 4;
      end
      CW'(2): begin
        add_a = quo_q;
        add_b = quo_q << 8;
      end
      CW'(3): begin
        add_a = quo_q;
        add_b = quo_q << 16;
      end
      CW'(4): begin
        add_a = quo_q;
        add_b = quo_q << 32;
      end
      CW'(5): begin
        add_a = half_q;
        add_b = quo_q << 1;
      end
      default: begin
        add_a = quo_q;
        add_b = '0;
      end
    endcase
  end

  assign quo_m1  = quo_q - Inv3;
  assign quo_m2  = quo_q - Inv3x2;
  assign quo_sel = (quo_q[63:61] == 3'b000)  ? quo_q :
                   (quo_m1[63:61] == 3'b000) ? quo_m1 : quo_m2;

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      half_q      <= {1'b0, mag_s[63:1]};
      neg_q       <= sum_q[63];
      step_q      <= '0;
      cnt_hold_q  <= cnt_q;
      clip_hold_q <= clip_q;
    end else if (cmd_i.div_step) begin
      quo_q  <= (step_q == CW'(DivSteps - 1)) ? quo_sel : add_a + add_b;
      step_q <= step_q + CW'(1);
    end
  end

  assign status_o.div_last = (step_q == CW'(DivSteps - 1));
  assign status_o.out_busy = out_valid_o;

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      volume_o     <= neg_q ? -$signed(quo_q) : $signed(quo_q);
      faces_seen_o <= cnt_hold_q;
      saturated_o  <= clip_hold_q;
    end
  end

endmodule

### hw/rtl/mesh_volume_accumulator_core.sv
// ----------------------------------------------------------------------------
// mesh_volume_accumulator_core
// Closed triangle mesh volume from stored vertices and streamed faces.
// ----------------------------------------------------------------------------
// A vertex store beat is written to the vertex memory when accepted. In a face
// beat the three corners are read one per cycle from the single-port vertex
// memory, then the third corner is captured and multiply, sum and saturating
// accumulate steps follow. A finish beat runs seven steps of divide by six (a
// shift-and-add multiply by the inverse of three and a final pick), then loads
// the result, after any wait for a previous result still in the output register.
module mesh_volume_accumulator_core
  import mva_pkg::*;
#(
  parameter int unsigned VERTEX_DEPTH = VertexDepthDflt
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         mode_i,
  input  logic [11:0]        vertex_slot_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic signed [15:0] pos_z_i,
  input  logic signed [15:0] norm_x_i,
  input  logic signed [15:0] norm_y_i,
  input  logic signed [15:0] norm_z_i,
  input  logic [11:0]        face_a_i,
  input  logic [11:0]        face_b_i,
  input  logic [11:0]        face_c_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [63:0] volume_o,
  output logic [31:0]        faces_seen_o,
  output logic               saturated_o
);

  cmd_t    cmd;
  status_t status;

  mva_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .mode_i     (mode_i),
    .status_i   (status),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  mva_datapath #(
    .VERTEX_DEPTH (VERTEX_DEPTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .vertex_slot_i (vertex_slot_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .pos_z_i       (pos_z_i),
    .norm_x_i      (norm_x_i),
    .norm_y_i      (norm_y_i),
    .norm_z_i      (norm_z_i),
    .face_a_i      (face_a_i),
    .face_b_i      (face_b_i),
    .face_c_i      (face_c_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .volume_o      (volume_o),
    .faces_seen_o  (faces_seen_o),
    .saturated_o   (saturated_o)
  );

endmodule

### hw/rtl/mva_checker.sv
// ----------------------------------------------------------------------------
// mva_checker
// Port-level checks on the mesh volume accumulator, bound to the top level.
// ----------------------------------------------------------------------------
module mva_checker
  import mva_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic [1:0]         mode_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [63:0] volume_o
);

  // a held result beat keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(volume_o))
    else $error("result changed while stalled");

  // a face beat keeps the input closed for its fetch
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && mode_i == MODE_FACE |=> !in_ready_o)
    else $error("input open during face fetch");

  // a finish beat keeps the input closed for the divide
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && mode_i == MODE_FINISH |=> !in_ready_o)
    else $error("input open during divide");

  // a new result only appears at the end of a finish sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without a finish");

endmodule

bind mesh_volume_accumulator_core mva_checker u_mva_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .mode_i      (mode_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .volume_o    (volume_o)
);
